// ===== hw/rtl/brftc_pkg.sv =====
package brftc_pkg;

    localparam int NUM_WORDS  = 16;
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int DATA_W     = 32;
    localparam int OFF_W      = 7;
    localparam int KIND_W     = 3;
    localparam int MODE_W     = 24;

    localparam logic [OFF_W-1:0] OFF_MODE    = 7'h00;
    localparam logic [OFF_W-1:0] OFF_FCLR    = 7'h04;
    localparam logic [OFF_W-1:0] OFF_WORDS   = 7'h08;
    localparam int               WORD_STRIDE = 4;
    localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(8 + (NUM_WORDS - 1) * WORD_STRIDE);

    // write-protect bits 0-7, read-protect bits 16-23
    localparam logic [MODE_W-1:0] MODE_KEEP_MASK     = 24'hff00ff;
    localparam int                PROTECTED_WORDS    = 8;
    localparam int                TAMPER_CLEAR_COUNT = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ      = 3'd0,
        KIND_WRITE     = 3'd1,
        KIND_TAMPER    = 3'd2,
        KIND_PWR_RESET = 3'd3,
        KIND_SYS_RESET = 3'd4
    } kind_t;

endpackage

// ===== hw/rtl/backup_register_file_with_tamper_clear_unit.sv =====
// Battery-backed register file on a 32-bit bus: a write-once mode word at offset 0x00,
// a full-clear enable bit at 0x04 and backup words from 0x08 on. Each transaction
// (bus read, bus write, tamper level change, backup power reset, system reset)
// returns one result. A transaction reads the word memory synchronously when accepted,
// then updates state and loads the output register once that register is free, and a
// new transaction is accepted only after the previous one has committed. Tamper and
// power-reset clears act on per-word valid bits, so no clearing pass is needed and
// an invalid word reads as zero.
module backup_register_file_with_tamper_clear_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [brftc_pkg::KIND_W-1:0] kind,
    input  logic [brftc_pkg::OFF_W-1:0]  offset,
    input  logic [brftc_pkg::DATA_W-1:0] write_data,
    input  logic                         write_protected,
    input  logic                         level,
    input  logic                         clear_allowed,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [brftc_pkg::DATA_W-1:0] read_data,
    output logic                         reserved_access
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                              state_reg;
    logic [brftc_pkg::KIND_W-1:0]        kind_reg;
    logic [brftc_pkg::OFF_W-1:0]         off_reg;
    logic [brftc_pkg::DATA_W-1:0]        wdata_reg;
    logic                                wp_reg;
    logic                                level_reg;
    logic                                allowed_reg;

    logic [brftc_pkg::MODE_W-1:0]        mode_reg, mode_next;
    logic                                locked_reg, locked_next;
    logic                                fce_reg, fce_next;
    logic                                tamper_reg, tamper_next;
    logic [brftc_pkg::NUM_WORDS-1:0]     vld_reg, vld_next;

    logic [brftc_pkg::DATA_W-1:0]        mem [brftc_pkg::NUM_WORDS];
    logic [brftc_pkg::DATA_W-1:0]        rdata_reg;

    logic [brftc_pkg::DATA_W-1:0]        read_data_next;
    logic                                reserved_next;

    logic                                accept;
    logic                                commit;
    logic [brftc_pkg::OFF_W-1:0]         in_rel;
    logic [brftc_pkg::WORD_IDX_W-1:0]    rd_addr;
    logic [brftc_pkg::OFF_W-1:0]         rel;
    logic [brftc_pkg::WORD_IDX_W-1:0]    idx;
    logic [brftc_pkg::OFF_W-3:0]         idx_wide;
    logic                                word_hit;
    logic                                word_low;
    logic                                hidden;
    logic                                wlocked;
    logic [brftc_pkg::DATA_W-1:0]        word_val;
    logic                                mem_we;
    logic [brftc_pkg::NUM_WORDS-1:0]     clr_mask;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid || out_ready);

    assign in_rel  = offset - brftc_pkg::OFF_WORDS;
    assign rd_addr = in_rel[brftc_pkg::WORD_IDX_W+1:2];

    // decode of the held transaction's offset
    assign rel      = off_reg - brftc_pkg::OFF_WORDS;
    assign idx      = rel[brftc_pkg::WORD_IDX_W+1:2];
    assign idx_wide = rel[brftc_pkg::OFF_W-1:2];
    assign word_hit = (off_reg >= brftc_pkg::OFF_WORDS) && (off_reg <= brftc_pkg::OFF_LAST)
                      && (off_reg[1:0] == 2'b00);
    assign word_low = (idx_wide < (brftc_pkg::OFF_W-2)'(brftc_pkg::PROTECTED_WORDS));
    assign hidden   = word_low && mode_reg[{2'b10, idx_wide[2:0]}];
    assign wlocked  = word_low && mode_reg[{2'b00, idx_wide[2:0]}];
    assign word_val = vld_reg[idx] ? rdata_reg : '0;

    always_comb
    begin
        for (int i = 0; i < brftc_pkg::NUM_WORDS; i++)
        begin
            clr_mask[i] = fce_reg || (i < brftc_pkg::TAMPER_CLEAR_COUNT);
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        locked_next    = locked_reg;
        fce_next       = fce_reg;
        tamper_next    = tamper_reg;
        vld_next       = vld_reg;
        read_data_next = '0;
        reserved_next  = 1'b0;
        mem_we         = 1'b0;
        unique case (kind_reg)
            brftc_pkg::KIND_READ:
            begin
                if (off_reg == brftc_pkg::OFF_MODE)
                    read_data_next = {{(brftc_pkg::DATA_W-brftc_pkg::MODE_W){1'b0}}, mode_reg};
                else if (off_reg == brftc_pkg::OFF_FCLR)
                    read_data_next = {{(brftc_pkg::DATA_W-1){1'b0}}, fce_reg};
                else if (word_hit)
                    read_data_next = hidden ? '0 : word_val;
                else
                    reserved_next = 1'b1;
            end
            brftc_pkg::KIND_WRITE:
            begin
                if (off_reg == brftc_pkg::OFF_MODE)
                begin
                    if (!wp_reg && !locked_reg)
                    begin
                        mode_next   = wdata_reg[brftc_pkg::MODE_W-1:0]
                                      & brftc_pkg::MODE_KEEP_MASK;
                        locked_next = 1'b1;
                    end
                end
                else if (off_reg == brftc_pkg::OFF_FCLR)
                begin
                    if (!wp_reg)
                        fce_next = wdata_reg[0];
                end
                else if (word_hit)
                begin
                    if (!wp_reg && !tamper_reg && !wlocked)
                    begin
                        mem_we        = 1'b1;
                        vld_next[idx] = 1'b1;
                    end
                end
                else
                    reserved_next = 1'b1;
            end
            brftc_pkg::KIND_TAMPER:
            begin
                // clear only on a rising edge
                if (level_reg && !tamper_reg && allowed_reg)
                    vld_next = vld_reg & ~clr_mask;
                tamper_next = level_reg;
            end
            brftc_pkg::KIND_PWR_RESET:
            begin
                if (level_reg)
                begin
                    mode_next   = '0;
                    locked_next = 1'b0;
                    fce_next    = 1'b0;
                    tamper_next = 1'b0;
                    vld_next    = '0;
                end
            end
            brftc_pkg::KIND_SYS_RESET:
            begin
                tamper_next = 1'b0;
            end
            default:
            begin
                // unknown kinds change nothing and return zero
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= mem[rd_addr];
        if (commit && mem_we)
            mem[idx] <= wdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            off_reg     <= offset;
            wdata_reg   <= write_data;
            wp_reg      <= write_protected;
            level_reg   <= level;
            allowed_reg <= clear_allowed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid       <= 1'b0;
            read_data       <= '0;
            reserved_access <= 1'b0;
            mode_reg        <= '0;
            locked_reg      <= 1'b0;
            fce_reg         <= 1'b0;
            tamper_reg      <= 1'b0;
            vld_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_valid && out_ready)
                        out_valid <= 1'b0;
                    if (accept)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    // hold until the output register is free
                    if (commit)
                    begin
                        state_reg       <= ST_IDLE;
                        out_valid       <= 1'b1;
                        read_data       <= read_data_next;
                        reserved_access <= reserved_next;
                        mode_reg        <= mode_next;
                        locked_reg      <= locked_next;
                        fce_reg         <= fce_next;
                        tamper_reg      <= tamper_next;
                        vld_reg         <= vld_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/brftc_checker.sv =====
module brftc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [brftc_pkg::DATA_W-1:0] read_data,
    input logic                         reserved_access
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
                                    && $stable(reserved_access))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // a reserved access never returns data
    a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reserved_access |-> read_data == '0)
        else $error("reserved access returned data");

    // a new result only follows an accepted transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without transaction");

endmodule

bind backup_register_file_with_tamper_clear_unit brftc_checker u_brftc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .reserved_access (reserved_access)
);
